/* rtl/core/march_x_walking_ones_memory_bist_macros.svh */
// Assertion macros used by the memory self-test sequencer.
`ifndef MARCH_X_WALKING_ONES_MEMORY_BIST_MACROS_SVH
`define MARCH_X_WALKING_ONES_MEMORY_BIST_MACROS_SVH

`ifndef SYNTHESIS
`define MBIST_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("mbist assertion failed");
`define MBIST_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("mbist assertion failed");
`else
`define MBIST_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define MBIST_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

/* rtl/core/mbist_pkg.sv */
`default_nettype none
package mbist_pkg;

    localparam int WORD_ADDR_BITS = 29;
    localparam int ADDR_W         = 30;
    localparam int SIZE_W         = 30;
    localparam int DATA_W         = 64;
    localparam int WDATA_W        = 32;
    localparam int BIT_W          = 5;
    localparam int CFG_DATA_W     = 30;

    localparam logic [SIZE_W-1:0] MAX_WORDS   = SIZE_W'(2 ** WORD_ADDR_BITS);
    localparam logic [SIZE_W-1:0] RESET_SIZE  = SIZE_W'(1024);
    localparam logic [BIT_W-1:0]  LAST_BIT    = BIT_W'(WDATA_W - 1);
    localparam logic [WDATA_W-1:0] ONES_PATTERN = WDATA_W'(8'hFF);

    localparam logic CFG_BASE_WORD  = 1'b0;
    localparam logic CFG_SIZE_WORDS = 1'b1;

    localparam logic REQ_START = 1'b0;
    localparam logic REQ_DONE  = 1'b1;

    typedef enum logic [3:0] {
        PH_IDLE   = 4'd0,
        PH_FILL   = 4'd1,
        PH_UP_RD  = 4'd2,
        PH_UP_WR  = 4'd3,
        PH_DN_RD  = 4'd4,
        PH_DN_WR  = 4'd5,
        PH_VER_RD = 4'd6,
        PH_WK_WR  = 4'd7,
        PH_WK_RD  = 4'd8,
        PH_WK_CLR = 4'd9
    } t_phase;

    typedef enum logic [1:0] {
        K_WRITE = 2'd0,
        K_READ  = 2'd1,
        K_PASS  = 2'd2,
        K_FAIL  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        FP_UP_RD  = 2'd0,
        FP_DN_RD  = 2'd1,
        FP_VER_RD = 2'd2,
        FP_WALK   = 2'd3
    } t_fail_phase;

    typedef struct packed {
        t_kind               kind;
        logic [ADDR_W-1:0]   word_address;
        logic [WDATA_W-1:0]  write_data;
        t_fail_phase         fail_phase;
        logic [BIT_W-1:0]    fail_bit;
    } t_rsp;

endpackage
`default_nettype wire

/* rtl/core/mbist_req_if.sv */
`default_nettype none
interface mbist_req_if;
    import mbist_pkg::*;

    logic              valid;
    logic              ready;
    logic              req_type;
    logic [DATA_W-1:0] read_data;

    modport source(output valid, output req_type, output read_data, input ready);
    modport sink(input valid, input req_type, input read_data, output ready);
endinterface
`default_nettype wire

/* rtl/core/mbist_rsp_if.sv */
`default_nettype none
interface mbist_rsp_if;
    import mbist_pkg::*;

    logic               valid;
    logic               ready;
    t_kind              kind;
    logic [ADDR_W-1:0]  word_address;
    logic [WDATA_W-1:0] write_data;
    t_fail_phase        fail_phase;
    logic [BIT_W-1:0]   fail_bit;

    modport source(output valid, output kind, output word_address, output write_data,
                   output fail_phase, output fail_bit, input ready);
    modport sink(input valid, input kind, input word_address, input write_data,
                 input fail_phase, input fail_bit, output ready);
endinterface
`default_nettype wire

/* rtl/core/mbist_seq.sv */
`default_nettype none
`include "march_x_walking_ones_memory_bist_macros.svh"
module mbist_seq (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic [mbist_pkg::WORD_ADDR_BITS-1:0]  i_base_word,
    input  wire logic [mbist_pkg::SIZE_W-1:0]          i_size_words,
    input  wire logic                                  i_step,
    input  wire logic                                  i_req_type,
    input  wire logic [mbist_pkg::DATA_W-1:0]          i_read_data,
    output      logic                                  o_emit,
    output      mbist_pkg::t_rsp                       o_rsp
);
    import mbist_pkg::*;

    t_phase              r_phase, n_phase;
    logic [SIZE_W-1:0]   r_offset, n_offset;
    logic [BIT_W-1:0]    r_bit, n_bit;

    logic [SIZE_W-1:0]   eff_size;
    logic [SIZE_W-1:0]   eff_m1;
    logic [ADDR_W-1:0]   base_addr;
    logic                more;
    logic [DATA_W-1:0]   walk_expect;

    always_comb begin
        if (i_size_words == '0) begin
            eff_size = SIZE_W'(1);
        end else if (i_size_words > MAX_WORDS) begin
            eff_size = MAX_WORDS;
        end else begin
            eff_size = i_size_words;
        end
    end

    assign eff_m1      = eff_size - SIZE_W'(1);
    assign more        = r_offset < eff_m1;
    assign base_addr   = ADDR_W'(i_base_word);
    assign walk_expect = DATA_W'(1) << r_bit;

    always_comb begin
        n_phase  = r_phase;
        n_offset = r_offset;
        n_bit    = r_bit;
        o_emit   = 1'b1;
        o_rsp.kind         = K_WRITE;
        o_rsp.word_address = '0;
        o_rsp.write_data   = '0;
        o_rsp.fail_phase   = FP_UP_RD;
        o_rsp.fail_bit     = '0;

        if (i_req_type == REQ_START) begin
            n_offset = '0;
            n_bit    = '0;
            n_phase  = PH_FILL;
        end else begin
            unique case (r_phase)
                PH_FILL: begin
                    if (more) begin
                        n_offset = r_offset + SIZE_W'(1);
                    end else begin
                        n_offset = '0;
                        n_phase  = PH_UP_RD;
                        o_rsp.kind = K_READ;
                    end
                end
                PH_UP_RD: begin
                    if (i_read_data != '0) begin
                        o_rsp.kind = K_FAIL;
                        n_phase    = PH_IDLE;
                    end else begin
                        o_rsp.write_data = ONES_PATTERN;
                        n_phase          = PH_UP_WR;
                    end
                end
                PH_UP_WR: begin
                    o_rsp.kind = K_READ;
                    if (more) begin
                        n_offset = r_offset + SIZE_W'(1);
                        n_phase  = PH_UP_RD;
                    end else begin
                        n_offset = eff_m1;
                        n_phase  = PH_DN_RD;
                    end
                end
                PH_DN_RD: begin
                    if (i_read_data != DATA_W'(ONES_PATTERN)) begin
                        o_rsp.kind       = K_FAIL;
                        o_rsp.fail_phase = FP_DN_RD;
                        n_phase          = PH_IDLE;
                    end else begin
                        n_phase = PH_DN_WR;
                    end
                end
                PH_DN_WR: begin
                    o_rsp.kind = K_READ;
                    if (r_offset != '0) begin
                        n_offset = r_offset - SIZE_W'(1);
                        n_phase  = PH_DN_RD;
                    end else begin
                        n_phase = PH_VER_RD;
                    end
                end
                PH_VER_RD: begin
                    if (i_read_data != '0) begin
                        o_rsp.kind       = K_FAIL;
                        o_rsp.fail_phase = FP_VER_RD;
                        n_phase          = PH_IDLE;
                    end else if (more) begin
                        o_rsp.kind = K_READ;
                        n_offset   = r_offset + SIZE_W'(1);
                    end else begin
                        n_offset         = '0;
                        n_bit            = '0;
                        o_rsp.write_data = WDATA_W'(1);
                        n_phase          = PH_WK_WR;
                    end
                end
                PH_WK_WR: begin
                    o_rsp.kind = K_READ;
                    n_phase    = PH_WK_RD;
                end
                PH_WK_RD: begin
                    if (i_read_data != walk_expect) begin
                        o_rsp.kind       = K_FAIL;
                        o_rsp.fail_phase = FP_WALK;
                        o_rsp.fail_bit   = r_bit;
                        n_phase          = PH_IDLE;
                    end else if (r_bit < LAST_BIT) begin
                        n_bit            = r_bit + BIT_W'(1);
                        o_rsp.write_data = WDATA_W'(1) << n_bit;
                        n_phase          = PH_WK_WR;
                    end else begin
                        n_phase = PH_WK_CLR;
                    end
                end
                PH_WK_CLR: begin
                    if (more) begin
                        n_offset         = r_offset + SIZE_W'(1);
                        n_bit            = '0;
                        o_rsp.write_data = WDATA_W'(1);
                        n_phase          = PH_WK_WR;
                    end else begin
                        o_rsp.kind = K_PASS;
                        n_phase    = PH_IDLE;
                    end
                end
                default: begin
                    o_emit  = 1'b0;
                    n_phase = PH_IDLE;
                end
            endcase
        end

        if (o_rsp.kind != K_PASS) begin
            o_rsp.word_address = base_addr + ADDR_W'(n_offset);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_offset <= '0;
            r_bit    <= '0;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_offset <= n_offset;
            r_bit    <= n_bit;
        end
    end

    `MBIST_ASSERT_NXT(a_end_to_idle, i_clk, i_rst_n,
        i_step && o_emit && (o_rsp.kind == K_PASS || o_rsp.kind == K_FAIL),
        r_phase == PH_IDLE)
    `MBIST_ASSERT_NXT(a_start_clears, i_clk, i_rst_n,
        i_step && i_req_type == REQ_START,
        r_phase == PH_FILL && r_offset == '0 && r_bit == '0)
    `MBIST_ASSERT_IMP(a_data_only_on_write, i_clk, i_rst_n,
        o_emit && o_rsp.kind != K_WRITE,
        o_rsp.write_data == '0)
endmodule
`default_nettype wire

/* rtl/core/march_x_walking_ones_memory_bist.sv */
// A request beat is held in the input register, its result beat in the result register.
// One request beat per cycle unless stalled; a completion outside idle gives the next command.
// A result waiting at the output holds the sequencer; the input takes a beat only while
// its register is empty or advancing.
// Reset (synchronous, active low) clears both pipeline valids, puts the sequencer in idle
// with offset and bit at zero, and sets base_word to 0 and size_words to 1024.
`default_nettype none
module march_x_walking_ones_memory_bist (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic                              i_cfg_idx,
    input  wire logic [mbist_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    mbist_req_if.sink                              i_req,
    mbist_rsp_if.source                            o_rsp
);
    import mbist_pkg::*;

    logic [WORD_ADDR_BITS-1:0] r_base_word;
    logic [SIZE_W-1:0]         r_size_words;

    logic                      r_in_valid;
    logic                      r_in_req;
    logic [DATA_W-1:0]         r_in_data;
    logic                      r_out_valid;
    t_rsp                      r_out;

    logic                      adv;
    logic                      emit;
    t_rsp                      rsp;

    assign adv         = r_in_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_word  <= '0;
            r_size_words <= RESET_SIZE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_BASE_WORD:  r_base_word  <= i_cfg_data[WORD_ADDR_BITS-1:0];
                CFG_SIZE_WORDS: r_size_words <= i_cfg_data[SIZE_W-1:0];
                default:        r_size_words <= r_size_words;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_in_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.ready && i_req.valid) begin
            r_in_req  <= i_req.req_type;
            r_in_data <= i_req.read_data;
        end
    end

    mbist_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_base_word  (r_base_word),
        .i_size_words (r_size_words),
        .i_step       (adv),
        .i_req_type   (r_in_req),
        .i_read_data  (r_in_data),
        .o_emit       (emit),
        .o_rsp        (rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= emit;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && emit) begin
            r_out <= rsp;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.kind         = r_out.kind;
    assign o_rsp.word_address = r_out.word_address;
    assign o_rsp.write_data   = r_out.write_data;
    assign o_rsp.fail_phase   = r_out.fail_phase;
    assign o_rsp.fail_bit     = r_out.fail_bit;
endmodule
`default_nettype wire

/* verif/march_x_walking_ones_memory_bist_checker.sv */
module march_x_walking_ones_memory_bist_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic                             i_cfg_idx,
    input  logic [mbist_pkg::CFG_DATA_W-1:0] i_cfg_data,
    mbist_req_if                             i_req_mon,
    mbist_rsp_if                             i_rsp_mon,
    output int                               o_fail_count,
    output int                               o_cmds_due
);
    import mbist_pkg::*;

    t_phase                    seq_phase;
    logic [ADDR_W-1:0]         seq_offset;
    logic [BIT_W-1:0]          seq_bit;
    logic [WORD_ADDR_BITS-1:0] range_base;
    logic [SIZE_W-1:0]         range_size;
    t_rsp                      upcoming_cmds[$];
    t_rsp                      oldest;
    int                        mismatches = 0;

    function automatic logic [SIZE_W-1:0] words_in_range();
        if (range_size == '0) return SIZE_W'(1);
        if (range_size > MAX_WORDS) return MAX_WORDS;
        return range_size;
    endfunction

    task automatic next_command(input logic req_type, input logic [DATA_W-1:0] rd);
        t_rsp cmd;
        logic more;
        logic issue;
        cmd            = '0;
        cmd.kind       = K_WRITE;
        cmd.fail_phase = FP_UP_RD;
        issue          = 1'b1;
        more           = ({1'b0, seq_offset} + 31'd1) < {1'b0, words_in_range()};
        if (req_type == REQ_START) begin
            seq_offset = '0;
            seq_bit    = '0;
            seq_phase  = PH_FILL;
        end else begin
            case (seq_phase)
                PH_FILL: begin
                    if (more) begin
                        seq_offset = seq_offset + 1'b1;
                    end else begin
                        seq_offset = '0;
                        seq_phase  = PH_UP_RD;
                        cmd.kind   = K_READ;
                    end
                end
                PH_UP_RD: begin
                    if (rd != '0) begin
                        cmd.kind   = K_FAIL;
                        seq_phase  = PH_IDLE;
                    end else begin
                        cmd.write_data = ONES_PATTERN;
                        seq_phase      = PH_UP_WR;
                    end
                end
                PH_UP_WR: begin
                    cmd.kind = K_READ;
                    if (more) begin
                        seq_offset = seq_offset + 1'b1;
                        seq_phase  = PH_UP_RD;
                    end else begin
                        seq_offset = ADDR_W'(words_in_range()) - 1'b1;
                        seq_phase  = PH_DN_RD;
                    end
                end
                PH_DN_RD: begin
                    if (rd != DATA_W'(ONES_PATTERN)) begin
                        cmd.kind       = K_FAIL;
                        cmd.fail_phase = FP_DN_RD;
                        seq_phase      = PH_IDLE;
                    end else begin
                        seq_phase = PH_DN_WR;
                    end
                end
                PH_DN_WR: begin
                    cmd.kind = K_READ;
                    if (seq_offset != '0) begin
                        seq_offset = seq_offset - 1'b1;
                        seq_phase  = PH_DN_RD;
                    end else begin
                        seq_phase = PH_VER_RD;
                    end
                end
                PH_VER_RD: begin
                    if (rd != '0) begin
                        cmd.kind       = K_FAIL;
                        cmd.fail_phase = FP_VER_RD;
                        seq_phase      = PH_IDLE;
                    end else if (more) begin
                        cmd.kind   = K_READ;
                        seq_offset = seq_offset + 1'b1;
                    end else begin
                        seq_offset     = '0;
                        seq_bit        = '0;
                        cmd.write_data = WDATA_W'(1);
                        seq_phase      = PH_WK_WR;
                    end
                end
                PH_WK_WR: begin
                    cmd.kind  = K_READ;
                    seq_phase = PH_WK_RD;
                end
                PH_WK_RD: begin
                    if (rd != (DATA_W'(1) << seq_bit)) begin
                        cmd.kind       = K_FAIL;
                        cmd.fail_phase = FP_WALK;
                        cmd.fail_bit   = seq_bit;
                        seq_phase      = PH_IDLE;
                    end else if (seq_bit != LAST_BIT) begin
                        seq_bit        = seq_bit + 1'b1;
                        cmd.write_data = WDATA_W'(1) << seq_bit;
                        seq_phase      = PH_WK_WR;
                    end else begin
                        seq_phase = PH_WK_CLR;
                    end
                end
                PH_WK_CLR: begin
                    if (more) begin
                        seq_offset     = seq_offset + 1'b1;
                        seq_bit        = '0;
                        cmd.write_data = WDATA_W'(1);
                        seq_phase      = PH_WK_WR;
                    end else begin
                        cmd.kind  = K_PASS;
                        seq_phase = PH_IDLE;
                    end
                end
                default: begin
                    seq_phase = PH_IDLE;
                    issue     = 1'b0;
                end
            endcase
        end
        if (cmd.kind != K_PASS) cmd.word_address = ADDR_W'(range_base) + seq_offset;
        if (issue) upcoming_cmds.push_back(cmd);
    endtask

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            seq_phase  = PH_IDLE;
            seq_offset = '0;
            seq_bit    = '0;
            range_base = '0;
            range_size = RESET_SIZE;
            upcoming_cmds.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_BASE_WORD) begin
                    range_base = i_cfg_data[WORD_ADDR_BITS-1:0];
                end else begin
                    range_size = i_cfg_data[SIZE_W-1:0];
                end
            end
            if (i_req_mon.valid && i_req_mon.ready) begin
                next_command(i_req_mon.req_type, i_req_mon.read_data);
            end
            if (i_rsp_mon.valid && i_rsp_mon.ready) begin
                if (upcoming_cmds.size() == 0) begin
                    mismatches++;
                    $display("%0t: beat expected none actual kind %0d", $time,
                             i_rsp_mon.kind);
                end else begin
                    oldest = upcoming_cmds.pop_front();
                    check_field("kind", 32'(oldest.kind), 32'(i_rsp_mon.kind));
                    check_field("word_address", 32'(oldest.word_address),
                                32'(i_rsp_mon.word_address));
                    check_field("write_data", oldest.write_data, i_rsp_mon.write_data);
                    check_field("fail_phase", 32'(oldest.fail_phase),
                                32'(i_rsp_mon.fail_phase));
                    check_field("fail_bit", 32'(oldest.fail_bit), 32'(i_rsp_mon.fail_bit));
                end
            end
        end
        o_fail_count <= mismatches;
        o_cmds_due   <= upcoming_cmds.size();
    end

endmodule

/* verif/march_x_walking_ones_memory_bist_tb.sv */
module march_x_walking_ones_memory_bist_tb;
    import mbist_pkg::*;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic                  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    fail_count;
    int                    cmds_due;
    longint unsigned       cur_words;
    int                    sent_items;
    bit                    seq_busy;
    bit                    tx_gaps;

    mbist_req_if req_if ();
    mbist_rsp_if rsp_if ();

    march_x_walking_ones_memory_bist u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_req      (req_if),
        .o_rsp      (rsp_if)
    );

    march_x_walking_ones_memory_bist_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_req_mon    (req_if),
        .i_rsp_mon    (rsp_if),
        .o_fail_count (fail_count),
        .o_cmds_due   (cmds_due)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #4_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic longint unsigned tested_words(input logic [CFG_DATA_W-1:0] sz);
        if (sz == '0) return 1;
        if (sz > MAX_WORDS) return MAX_WORDS;
        return sz;
    endfunction

    // 71 commands per word: fill, up read/write, down read/write, verify, 65 walking
    function automatic bit read_slot(input longint unsigned n, input longint unsigned c,
                                     output logic [DATA_W-1:0] good);
        longint unsigned w;
        good = '0;
        if (c < n) return 1'b0;
        if (c < 3 * n) return ((c - n) % 2) == 0;
        if (c < 5 * n) begin
            good = DATA_W'(ONES_PATTERN);
            return ((c - 3 * n) % 2) == 0;
        end
        if (c < 6 * n) return 1'b1;
        w = (c - 6 * n) % 65;
        if (w == 64 || (w % 2) == 0) return 1'b0;
        good = DATA_W'(1) << (w / 2);
        return 1'b1;
    endfunction

    function automatic longint unsigned first_read_from(input longint unsigned n,
                                                        input longint unsigned c);
        logic [DATA_W-1:0] good;
        while (c < 71 * n && !read_slot(n, c, good)) c++;
        return c;
    endfunction

    function automatic logic [DATA_W-1:0] noise_word();
        case ($urandom_range(3))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] flip_mask();
        logic [DATA_W-1:0] m;
        if ($urandom_range(1) == 0) return DATA_W'(1) << $urandom_range(DATA_W - 1);
        m = {$urandom, $urandom};
        return (m == '0) ? DATA_W'(1) : m;
    endfunction

    task automatic put_beat(input logic kind_of_req, input logic [DATA_W-1:0] data);
        while (tx_gaps && $urandom_range(99) < 7) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid     <= 1'b1;
        req_if.req_type  <= kind_of_req;
        req_if.read_data <= data;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
    endtask

    // start, then good completions up to stop_at; a corrupted read there if asked
    task automatic run_test(input longint unsigned stop_at, input bit corrupt);
        logic [DATA_W-1:0] good;
        longint unsigned   c;
        bit                is_rd;
        put_beat(REQ_START, noise_word());
        sent_items++;
        for (c = 0; c < stop_at && c < 71 * cur_words; c++) begin
            is_rd = read_slot(cur_words, c, good);
            put_beat(REQ_DONE, is_rd ? good : noise_word());
            sent_items++;
        end
        if (corrupt && c < 71 * cur_words) begin
            is_rd = read_slot(cur_words, c, good);
            put_beat(REQ_DONE, good ^ flip_mask());
            sent_items++;
        end
        seq_busy = !(corrupt || stop_at >= 71 * cur_words);
    endtask

    task automatic drain();
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (cmds_due != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic program_range(input logic [CFG_DATA_W-1:0] base,
                                 input logic [CFG_DATA_W-1:0] sz);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_BASE_WORD;
        cfg_data <= base;
        @(posedge i_clk);
        cfg_idx  <= CFG_SIZE_WORDS;
        cfg_data <= sz;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        cur_words = tested_words(sz);
    endtask

    initial begin : rsp_side
        int cyc;
        rsp_if.ready = 1'b0;
        cyc          = 0;
        forever begin
            if (cyc == 300 || cyc == 2000) begin
                rsp_if.ready <= 1'b0;
                repeat (120) @(posedge i_clk);
                cyc += 120;
            end else begin
                rsp_if.ready <= !((cyc < 700 || cyc >= 1400) && $urandom_range(99) < 7);
                @(posedge i_clk);
                cyc++;
            end
        end
    end

    initial begin : stimulus
        int                    guard;
        int                    pick;
        longint unsigned       n;
        logic [CFG_DATA_W-1:0] base_val;
        logic [CFG_DATA_W-1:0] size_val;
        i_rst_n          = 1'b0;
        cfg_we           = 1'b0;
        cfg_idx          = CFG_BASE_WORD;
        cfg_data         = '0;
        req_if.valid     = 1'b0;
        req_if.req_type  = REQ_START;
        req_if.read_data = '0;
        sent_items       = 0;
        seq_busy         = 1'b0;
        tx_gaps          = 1'b1;
        cur_words        = tested_words(RESET_SIZE);
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // top base with an out-of-range bit set, zero size
        program_range('1, '0);
        put_beat(REQ_DONE, '1);
        run_test(1, 1'b1);
        put_beat(REQ_START, noise_word());
        run_test(3, 1'b1);
        run_test(5, 1'b1);
        run_test(7, 1'b1);

        while (sent_items < 1750) begin
            tx_gaps = !(sent_items >= 600 && sent_items < 1000);
            if (!seq_busy && $urandom_range(99) < 30) begin
                drain();
                case ($urandom_range(3))
                    0:       base_val = '0;
                    1:       base_val = '1;
                    default: base_val = CFG_DATA_W'($urandom);
                endcase
                case ($urandom_range(9))
                    0:       size_val = '0;
                    1, 2:    size_val = CFG_DATA_W'($urandom_range(4, 6));
                    default: size_val = CFG_DATA_W'($urandom_range(1, 3));
                endcase
                program_range(base_val, size_val);
            end
            n    = cur_words;
            pick = $urandom_range(99);
            if (pick < 45) begin
                run_test(71 * n, 1'b0);
            end else if (pick < 85) begin
                run_test(first_read_from(n, $urandom_range(32'(71 * n - 2))), 1'b1);
                if ($urandom_range(4) == 0) put_beat(REQ_DONE, noise_word());
            end else begin
                run_test($urandom_range(32'(71 * n - 1)), 1'b0);
            end
        end
        if (seq_busy) run_test(first_read_from(cur_words, 0), 1'b1);

        // saturated, oversized or reset-size ranges: only restarts early in the fill
        drain();
        case ($urandom_range(3))
            0:       size_val = '1;
            1:       size_val = MAX_WORDS;
            2:       size_val = MAX_WORDS + 1'b1;
            default: size_val = RESET_SIZE;
        endcase
        program_range(CFG_DATA_W'($urandom), size_val);
        repeat (6) run_test($urandom_range(30), 1'b0);

        req_if.valid <= 1'b0;
        for (guard = 0; guard < 20000 && cmds_due != 0; guard++) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && cmds_due == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
